[rtl/pjw_pkg.sv]
// Package for the PJW hash unit: the modulus and the per-byte and
// reduction functions that the datapath uses.
// No dependencies.
package pjw_pkg;

  localparam int unsigned StateW = 28;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned HashW  = 24;

  // 65536 * 255 - 1
  localparam logic [HashW-1:0] Modulus = 24'hFE_FFFF;

  typedef logic [StateW-1:0] state_t;
  typedef logic [HashW-1:0]  hash_t;

  // One byte of the hash: shift in the byte, then fold a nonzero top
  // nibble down to bits 7..4 and drop it. XOR with a zero nibble is a
  // no-op, so no test on the nibble is needed.
  function automatic state_t pjw_update(input state_t acc, input logic [ByteW-1:0] key);
    logic [31:0] v;
    logic [3:0]  top;
    v   = {acc, 4'b0000} + {24'd0, key};
    top = v[31:28];
    return v[27:0] ^ {20'd0, top, 4'b0000};
  endfunction

  // Reduction of a 28-bit value modulo 2^24 - 2^16 - 1. Since
  // 2^24 = 2^16 + 1 modulo the modulus, the top nibble folds back at
  // bits 16 and 0; the sum stays below twice the modulus, so one
  // conditional subtract finishes the job.
  function automatic hash_t pjw_mod(input state_t x);
    logic [HashW:0] s;
    logic [HashW:0] d;
    s = {1'b0, x[23:0]} + {5'd0, x[27:24], 16'd0} + {21'd0, x[27:24]};
    d = s - {1'b0, Modulus};
    return (s >= {1'b0, Modulus}) ? d[HashW-1:0] : s[HashW-1:0];
  endfunction

endpackage

[rtl/pjw_hash_with_modulo_unit.sv]
// PJW hash unit: hashes a key one byte per request and returns the hash
// modulo 16711679 after the final byte. Depends on pjw_pkg.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+--------------------------
//   in      | input     | in_valid_i / in_ready_o   | key_byte_i, final_byte_i
//   out     | output    | out_valid_o / out_ready_i | hash_value_o
//
// One byte is taken every cycle while in_ready_o is high, and the running
// hash updates in the cycle the byte is accepted. For a final byte, one
// register holds the finished 28-bit hash, the next holds the reduced value.
// Reset clears the running hash and both valid flags. A stalled output
// backs up into the finished-hash register and only then drops in_ready_o.
module pjw_hash_with_modulo_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] key_byte_i,
  input  logic       final_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [23:0] hash_value_o
);

  pjw_pkg::state_t run_q, run_d;
  pjw_pkg::state_t fin_q;
  logic            fin_valid_q, fin_valid_d;
  pjw_pkg::hash_t  res_q;
  logic            res_valid_q, res_valid_d;

  pjw_pkg::state_t next_hash;
  logic            in_acc;
  logic            fin_adv;

  assign next_hash = pjw_pkg::pjw_update(run_q, key_byte_i);

  // The result register can take a new value when empty or being drained.
  assign fin_adv    = fin_valid_q && (!res_valid_q || out_ready_i);
  assign in_ready_o = !fin_valid_q || fin_adv;
  assign in_acc     = in_valid_i && in_ready_o;

  always_comb begin
    run_d = run_q;
    if (in_acc) begin
      run_d = final_byte_i ? '0 : next_hash;
    end
  end

  always_comb begin
    fin_valid_d = fin_valid_q;
    if (in_acc && final_byte_i) begin
      fin_valid_d = 1'b1;
    end else if (fin_adv) begin
      fin_valid_d = 1'b0;
    end
  end

  always_comb begin
    res_valid_d = res_valid_q;
    if (fin_adv) begin
      res_valid_d = 1'b1;
    end else if (out_ready_i) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q       <= '0;
      fin_valid_q <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      run_q       <= run_d;
      fin_valid_q <= fin_valid_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && final_byte_i) begin
      fin_q <= next_hash;
    end
    if (fin_adv) begin
      res_q <= pjw_pkg::pjw_mod(fin_q);
    end
  end

  assign out_valid_o  = res_valid_q;
  assign hash_value_o = res_q;

`ifndef NO_ASSERTIONS
  a_final_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && final_byte_i |=> fin_valid_q && run_q == '0)
    else $error("final byte did not load the finished hash or clear the running hash");

  a_run_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_acc |=> $stable(run_q))
    else $error("running hash changed without an accepted request");

  a_result_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> hash_value_o < pjw_pkg::Modulus)
    else $error("result not reduced below the modulus");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> fin_valid_q && res_valid_q && !out_ready_i)
    else $error("input stalled while the pipeline could move");

  a_adv_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_adv |=> res_valid_q)
    else $error("advanced hash did not reach the result register");
`endif

endmodule

[sim/tb.sv]
// Testbench for the PJW hash unit: drives keys byte by byte, predicts each
// hash and checks every result against it in order.
// Depends on pjw_pkg and pjw_hash_with_modulo_unit.
module tb;

  typedef logic [7:0] key_q_t[$];

  localparam int unsigned WatchdogLimit = 1000;
  localparam int unsigned DrainCycles   = 40;
  localparam int unsigned HoldOffCycles = 80;
  localparam int unsigned ByteBudget    = 645;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [7:0]         key_byte_i;
  logic               final_byte_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [23:0]        hash_value_o;

  pjw_pkg::state_t    key_hash_acc;
  pjw_pkg::hash_t     expected_hash_q[$];
  int                 bytes_sent;
  int                 keys_sent;
  int                 hashes_checked;
  int                 errors;
  int                 hold_cycles;
  bit                 no_idle;

  pjw_hash_with_modulo_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .key_byte_i  (key_byte_i),
    .final_byte_i(final_byte_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .hash_value_o(hash_value_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Shift in one byte; a nonzero top nibble is folded down to bits 7..4
  // and then dropped, so the running value stays within 28 bits.
  function automatic pjw_pkg::state_t fold_in_byte(input pjw_pkg::state_t acc,
                                                   input logic [7:0] kbyte);
    logic [31:0] word;
    logic [31:0] nib;
    word = {acc, 4'h0} + {24'h0, kbyte};
    nib  = word & 32'hF000_0000;
    if (nib != 32'h0) word = word ^ (nib >> 24) ^ nib;
    return word[27:0];
  endfunction

  function automatic pjw_pkg::hash_t reduce_hash(input pjw_pkg::state_t acc);
    logic [31:0] rem;
    rem = {4'h0, acc} % {8'h0, pjw_pkg::Modulus};
    return rem[23:0];
  endfunction

  function automatic int draw_idle();
    return no_idle ? 0 : $urandom_range(0, 19);
  endfunction

  // Sends one byte request and updates the prediction when it is taken.
  task automatic send_key_byte(input logic [7:0] kbyte, input logic is_last);
    int gap;
    gap = draw_idle();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    key_byte_i   <= kbyte;
    final_byte_i <= is_last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    key_hash_acc = fold_in_byte(key_hash_acc, kbyte);
    bytes_sent++;
    if (is_last) begin
      expected_hash_q.push_back(reduce_hash(key_hash_acc));
      key_hash_acc = '0;
      keys_sent++;
    end
  endtask

  task automatic send_key(input key_q_t key);
    foreach (key[i]) send_key_byte(key[i], i == key.size() - 1);
  endtask

  // Field extremes, a hash that equals the modulus, the largest hash
  // below it, and two keys that reach bit 31: one folds the top nibble,
  // the other carries out of 32 bits on its last add.
  task automatic test_directed_keys();
    send_key('{8'h00});
    send_key('{8'hFF});
    send_key('{8'h0F, 8'h0E, 8'h0F, 8'h0F, 8'h0F, 8'h0F});
    send_key('{8'h0F, 8'h0E, 8'h0F, 8'h0F, 8'h0F, 8'h0E});
    send_key('{8'h0F, 8'h0F, 8'h0F, 8'h0F, 8'h0F, 8'h0F, 8'h0F, 8'h0F});
    send_key('{8'h0F, 8'h0F, 8'h0F, 8'h0F, 8'h0F, 8'h0F, 8'h0F, 8'hF0});
  endtask

  // The receiver holds off while one-byte keys arrive back to back, so
  // the unit fills up and must stall its input.
  task automatic test_output_backpressure();
    no_idle     = 1'b1;
    hold_cycles = HoldOffCycles;
    repeat (16) send_key_byte(8'($urandom_range(0, 255)), 1'b1);
    no_idle = 1'b0;
  endtask

  task automatic test_random_keys(input int byte_budget);
    key_q_t key;
    int     len;
    int     pick;
    while (bytes_sent < byte_budget) begin
      if ($urandom_range(0, 9) == 0) no_idle = !no_idle;
      len = ($urandom_range(0, 3) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 10);
      key.delete();
      repeat (len) begin
        pick = $urandom_range(0, 7);
        if (pick == 0) key.push_back(8'h00);
        else if (pick == 1) key.push_back(8'hFF);
        else key.push_back(8'($urandom_range(0, 255)));
      end
      send_key(key);
    end
    no_idle = 1'b0;
  endtask

  // Result side: random stalls per result, or a long hold-off on request.
  initial begin
    int stall;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_cycles > 0) begin
        stall       = hold_cycles;
        hold_cycles = 0;
      end else begin
        stall = draw_idle();
      end
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      if (expected_hash_q.size() == 0) begin
        $display("%0t: unexpected hash 0x%06h with nothing pending", $time, hash_value_o);
        errors++;
      end else begin
        if (hash_value_o !== expected_hash_q[0]) begin
          $display("%0t: hash mismatch, expected 0x%06h, got 0x%06h",
                   $time, expected_hash_q[0], hash_value_o);
          errors++;
        end
        void'(expected_hash_q.pop_front());
        hashes_checked++;
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(posedge clk_i);
      if (rst_ni && ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))) quiet = 0;
      else quiet++;
    end
    $display("%0t: no progress for %0d cycles, %0d hashes still pending",
             $time, WatchdogLimit, expected_hash_q.size());
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    key_byte_i     = 8'h00;
    final_byte_i   = 1'b0;
    out_ready_i    = 1'b0;
    key_hash_acc   = '0;
    bytes_sent     = 0;
    keys_sent      = 0;
    hashes_checked = 0;
    errors         = 0;
    hold_cycles    = 0;
    no_idle        = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_keys();
    test_output_backpressure();
    test_random_keys(ByteBudget);
    in_valid_i <= 1'b0;

    while (expected_hash_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (out_valid_o) begin
      $display("%0t: extra hash 0x%06h offered after the last key", $time, hash_value_o);
      errors++;
    end

    $display("Hashed %0d bytes in %0d keys and checked %0d results,", bytes_sent, keys_sent,
             hashes_checked);
    $display("with random gaps on both sides and one long output hold-off.");
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", errors);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
